// File: rtl/altitude_hold_pid_unit_defines.svh
// ----------------------------------------------------------------------------
// Altitude hold PID unit: assertion macros
// Shared property wrappers, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_HOLD_PID_UNIT_DEFINES_SVH
`define ALTITUDE_HOLD_PID_UNIT_DEFINES_SVH

// The consequent must hold on the same edge as the antecedent.
`define AHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold on the edge after the antecedent.
`define AHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ahp_pkg.sv
// ----------------------------------------------------------------------------
// Altitude hold PID unit: package
// Register indexes, fixed datapath widths and constants of the controller.
// ----------------------------------------------------------------------------
package ahp_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P             = 3'd0,
        REG_GAIN_I             = 3'd1,
        REG_GAIN_D             = 3'd2,
        REG_INTEGRAL_LIMIT     = 3'd3,
        REG_ERROR_BAND         = 3'd4,
        REG_WINDUP_LIMIT       = 3'd5,
        REG_DESCENT_RATE_LIMIT = 3'd6
    } cfg_reg_t;

    // Reset values of the limits, Q16.16.
    localparam logic [30:0] ERROR_BAND_RST   = 31'd655360;
    localparam logic [30:0] WINDUP_LIMIT_RST = 31'd6553600;

    // Sample interval window in microseconds.
    localparam logic [16:0] DT_MIN_US    = 17'd10000;
    localparam logic [16:0] DT_MAX_US    = 17'd100000;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // One step of the descent threshold: 10 m/s in Q16.16.
    localparam logic [27:0] DESCENT_STEP = 28'd655360;

    // Shared multiplier: signed A by unsigned B.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = 55;

    // Divider: signed dividend, magnitude width and remainder width.
    localparam int ACC_W = 57;
    localparam int MAG_W = 56;
    localparam int REM_W = 20;

endpackage

// File: rtl/altitude_hold_pid_unit.sv
// ----------------------------------------------------------------------------
// Altitude hold PID unit
// One controller step per barometer sample: interval clamp, limited error and
// error sum, climb rate, P/I/D terms, descent limiter and slewed throttle.
//
// Usage: configuration is written through cfg_wr_en/cfg_index/cfg_wr_data,
// one register per cycle, while no sample is in progress. Samples enter on
// the s_ channel (valid/ready) and each gives exactly one result beat on the
// m_ channel. The work runs on one shared multiplier and a radix-4 divider
// under a sequencer: six multiplies, five before the two divisions and one after.
// A new sample is taken only once the result of the last one has been loaded
// into the output register; the two divisions take most of that time.
// The result sits in an output register, so a stalled receiver does not hold
// off the next input beat; only the following result waits for it.
// A synchronous low aresetn clears all controller state and the registers
// return to their reset values; no beat is pending afterwards.
// ----------------------------------------------------------------------------
`include "altitude_hold_pid_unit_defines.svh"

module altitude_hold_pid_unit #(
    parameter int MAX_COMP = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [ahp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ahp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_time_us,
    input  logic signed [31:0]                  s_target_alt,
    input  logic signed [31:0]                  s_measured_alt,
    input  logic signed [31:0]                  s_bias_comp,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [7:0]                   m_throttle_comp,
    output logic signed [31:0]                  m_climb_rate,
    output logic [7:0]                          m_descent_count,
    output logic signed [31:0]                  m_max_climb,
    output logic signed [31:0]                  m_min_climb
);

    localparam int MAW = ahp_pkg::MUL_A_W;
    localparam int MBW = ahp_pkg::MUL_B_W;
    localparam int PW  = ahp_pkg::PROD_W;
    localparam int AW  = ahp_pkg::ACC_W;
    localparam int MW  = ahp_pkg::MAG_W;
    localparam int RW  = ahp_pkg::REM_W;
    localparam int DIV_STEPS = MW / 2;
    localparam int DCW = $clog2(DIV_STEPS);

    localparam logic signed [PW-1:0] COMP_LIM_Q = PW'(MAX_COMP * 65536);
    localparam logic [7:0]           DESC_CAP   = 8'(2 * MAX_COMP);
    localparam logic signed [7:0]    COMP_MAX   = 8'(MAX_COMP);
    localparam logic signed [35:0]   GOAL_MAX   = 36'(MAX_COMP);
    localparam logic signed [AW-1:0] RATE_MAX   = AW'(64'sh7FFF_FFFF);
    localparam logic signed [AW-1:0] RATE_MIN   = -RATE_MAX - AW'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_R,
        ST_MUL_AL,
        ST_MUL_AH,
        ST_ACC,
        ST_LD_I,
        ST_DIV,
        ST_FIN_I,
        ST_FIN_R,
        ST_MUL_D,
        ST_TERM_D,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [15:0]            gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]            ilim_reg, eband_reg, wlim_reg;
    logic [7:0]             drl_reg;

    // Controller state.
    logic [31:0]            last_time_reg;
    logic signed [31:0]     last_alt_reg, esum_reg;
    logic [7:0]             lim_reg;
    logic signed [7:0]      comp_reg;
    logic signed [31:0]     max_reg, min_reg;

    // Per-sample working registers.
    logic [16:0]            dt_reg;
    logic signed [31:0]     e_reg, bias_reg;
    logic signed [32:0]     diff_reg;
    logic signed [PW-1:0]   prod_reg, rdiv_reg;
    logic signed [23:0]     p_reg, d_reg;
    logic signed [39:0]     a_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [31:0]     i_reg, rate_reg;

    // Divider.
    logic [MW-1:0]          div_quo_reg;
    logic [RW-1:0]          div_rem_reg, div_den_reg;
    logic                   div_neg_reg, div_rate_reg;
    logic [DCW-1:0]         div_cnt_reg;

    // Result register.
    logic                   m_valid_reg;
    logic signed [7:0]      out_comp_reg;
    logic signed [31:0]     out_rate_reg, out_max_reg, out_min_reg;
    logic [7:0]             out_lim_reg;

    // Combinational values.
    logic [31:0]            dt_raw;
    logic [16:0]            dt_next;
    logic signed [32:0]     e_raw, eband_s, eband_neg;
    logic signed [31:0]     e_next;
    logic signed [32:0]     diff_next;
    logic signed [32:0]     esum_raw, wlim_s, wlim_neg;
    logic signed [31:0]     esum_next;
    logic signed [MAW-1:0]  mul_a;
    logic [MBW-1:0]         mul_b;
    logic signed [PW-1:0]   mul_res, prod_sh;
    logic signed [23:0]     term_next;
    logic signed [AW-1:0]   acc_sum;
    logic signed [AW-1:0]   div_src, div_src_abs;
    logic [RW-1:0]          div_den_next;
    logic [MW-1:0]          div_quo_next;
    logic [RW-1:0]          div_rem_next;
    logic signed [AW-1:0]   q_ext, q_floor, ilim_s;
    logic signed [31:0]     i_next, rate_next;
    logic [27:0]            desc_thr;
    logic signed [33:0]     desc_chk;
    logic [7:0]             lim_next;
    logic signed [35:0]     sum_w, goal_raw;
    logic signed [7:0]      goal_c, comp_next;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_throttle_comp = out_comp_reg;
    assign m_climb_rate    = out_rate_reg;
    assign m_descent_count = out_lim_reg;
    assign m_max_climb     = out_max_reg;
    assign m_min_climb     = out_min_reg;

    // Input conditioning, done as the sample is taken.
    always_comb begin
        dt_raw = s_time_us - last_time_reg;
        if (dt_raw < 32'(ahp_pkg::DT_MIN_US)) begin
            dt_next = ahp_pkg::DT_MIN_US;
        end else if (dt_raw > 32'(ahp_pkg::DT_MAX_US)) begin
            dt_next = ahp_pkg::DT_MAX_US;
        end else begin
            dt_next = dt_raw[16:0];
        end

        e_raw     = {s_target_alt[31], s_target_alt} - {s_measured_alt[31], s_measured_alt};
        eband_s   = {2'b00, eband_reg};
        eband_neg = -eband_s;
        if (e_raw > eband_s) begin
            e_next = eband_s[31:0];
        end else if (e_raw < eband_neg) begin
            e_next = eband_neg[31:0];
        end else begin
            e_next = e_raw[31:0];
        end

        diff_next = {s_measured_alt[31], s_measured_alt} - {last_alt_reg[31], last_alt_reg};
    end

    // Error sum with windup clamp.
    always_comb begin
        esum_raw = {esum_reg[31], esum_reg} + {e_reg[31], e_reg};
        wlim_s   = {2'b00, wlim_reg};
        wlim_neg = -wlim_s;
        if (esum_raw > wlim_s) begin
            esum_next = wlim_s[31:0];
        end else if (esum_raw < wlim_neg) begin
            esum_next = wlim_neg[31:0];
        end else begin
            esum_next = esum_raw[31:0];
        end
    end

    // Shared multiplier operand selection. The product is registered every cycle.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_P: begin
                mul_a = {{(MAW-32){e_reg[31]}}, e_reg};
                mul_b = {{(MBW-16){1'b0}}, gain_p_reg};
            end
            ST_MUL_I: begin
                mul_a = {{(MAW-32){esum_reg[31]}}, esum_reg};
                mul_b = {{(MBW-16){1'b0}}, gain_i_reg};
            end
            ST_MUL_R: begin
                mul_a = {{(MAW-33){diff_reg[32]}}, diff_reg};
                mul_b = ahp_pkg::USEC_PER_SEC;
            end
            ST_MUL_AL: begin
                mul_a = {{(MAW-24){1'b0}}, a_reg[23:0]};
                mul_b = {{(MBW-17){1'b0}}, dt_reg};
            end
            ST_MUL_AH: begin
                mul_a = {{(MAW-16){a_reg[39]}}, a_reg[39:24]};
                mul_b = {{(MBW-17){1'b0}}, dt_reg};
            end
            ST_MUL_D: begin
                mul_a = {{(MAW-32){rate_reg[31]}}, rate_reg};
                mul_b = {{(MBW-16){1'b0}}, gain_d_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * $signed({1'b0, mul_b});
    end

    // Q8.8 gain scaling is a floor shift; P and D share the same limit.
    always_comb begin
        prod_sh = prod_reg >>> 8;
        if (prod_sh > COMP_LIM_Q) begin
            term_next = COMP_LIM_Q[23:0];
        end else if (prod_sh < -COMP_LIM_Q) begin
            term_next = 24'(-COMP_LIM_Q);
        end else begin
            term_next = prod_sh[23:0];
        end
        // The upper part of the split product carries a weight of 2^24.
        acc_sum = acc_reg + ({{(AW-PW){prod_reg[PW-1]}}, prod_reg} <<< 24);
    end

    // Divider load: magnitude of the dividend, the sign kept apart.
    always_comb begin
        if (state_reg == ST_FIN_I) begin
            div_src      = {{(AW-PW){rdiv_reg[PW-1]}}, rdiv_reg};
            div_den_next = {{(RW-17){1'b0}}, dt_reg};
        end else begin
            div_src      = acc_reg;
            div_den_next = ahp_pkg::USEC_PER_SEC;
        end
        div_src_abs = div_src[AW-1] ? -div_src : div_src;
    end

    // Two restoring steps per cycle.
    always_comb begin
        logic [RW:0]   rem_w;
        logic [RW-1:0] rem_t;
        logic [MW-1:0] quo_w;
        quo_w = div_quo_reg;
        rem_t = div_rem_reg;
        for (int k = 0; k < 2; k++) begin
            rem_w = {rem_t, quo_w[MW-1]};
            quo_w = {quo_w[MW-2:0], 1'b0};
            if (rem_w >= {1'b0, div_den_reg}) begin
                rem_w    = rem_w - {1'b0, div_den_reg};
                quo_w[0] = 1'b1;
            end
            rem_t = rem_w[RW-1:0];
        end
        div_quo_next = quo_w;
        div_rem_next = rem_t;
    end

    // Floor quotient: a negative dividend with a remainder rounds one further down.
    always_comb begin
        q_ext = {1'b0, div_quo_reg};
        if (div_neg_reg) begin
            q_floor = -q_ext - {{(AW-1){1'b0}}, |div_rem_reg};
        end else begin
            q_floor = q_ext;
        end

        ilim_s = {{(AW-31){1'b0}}, ilim_reg};
        if (q_floor > ilim_s) begin
            i_next = ilim_s[31:0];
        end else if (q_floor < -ilim_s) begin
            i_next = 32'(-ilim_s);
        end else begin
            i_next = q_floor[31:0];
        end

        if (q_floor > RATE_MAX) begin
            rate_next = RATE_MAX[31:0];
        end else if (q_floor < RATE_MIN) begin
            rate_next = RATE_MIN[31:0];
        end else begin
            rate_next = q_floor[31:0];
        end
    end

    // Descent limiter, final sum and slew.
    always_comb begin
        desc_thr = 28'(drl_reg) * ahp_pkg::DESCENT_STEP;
        desc_chk = {{2{rate_reg[31]}}, rate_reg} + {6'b0, desc_thr};
        if (desc_chk[33]) begin
            lim_next = (lim_reg < DESC_CAP) ? lim_reg + 8'd1 : DESC_CAP;
        end else begin
            lim_next = (lim_reg != 8'd0) ? lim_reg - 8'd1 : 8'd0;
        end

        sum_w = {{12{p_reg[23]}}, p_reg} + {{4{i_reg[31]}}, i_reg}
              + {{12{d_reg[23]}}, d_reg} + {{4{bias_reg[31]}}, bias_reg}
              + {12'b0, lim_reg, 16'b0};
        // The integer part is taken towards zero.
        goal_raw = (sum_w + (sum_w[35] ? 36'sd65535 : 36'sd0)) >>> 16;
        if (goal_raw > GOAL_MAX) begin
            goal_c = COMP_MAX;
        end else if (goal_raw < -GOAL_MAX) begin
            goal_c = -COMP_MAX;
        end else begin
            goal_c = goal_raw[7:0];
        end

        if (goal_c > comp_reg) begin
            comp_next = comp_reg + 8'sd1;
        end else if (goal_c < comp_reg) begin
            comp_next = comp_reg - 8'sd1;
        end else begin
            comp_next = comp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            ilim_reg      <= '0;
            eband_reg     <= ahp_pkg::ERROR_BAND_RST;
            wlim_reg      <= ahp_pkg::WINDUP_LIMIT_RST;
            drl_reg       <= '0;
            last_time_reg <= '0;
            last_alt_reg  <= '0;
            esum_reg      <= '0;
            lim_reg       <= '0;
            comp_reg      <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            div_cnt_reg   <= '0;
            div_rate_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ahp_pkg::REG_GAIN_P:             gain_p_reg <= cfg_wr_data[15:0];
                    ahp_pkg::REG_GAIN_I:             gain_i_reg <= cfg_wr_data[15:0];
                    ahp_pkg::REG_GAIN_D:             gain_d_reg <= cfg_wr_data[15:0];
                    ahp_pkg::REG_INTEGRAL_LIMIT:     ilim_reg   <= cfg_wr_data;
                    ahp_pkg::REG_ERROR_BAND:         eband_reg  <= cfg_wr_data;
                    ahp_pkg::REG_WINDUP_LIMIT:       wlim_reg   <= cfg_wr_data;
                    ahp_pkg::REG_DESCENT_RATE_LIMIT: drl_reg    <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end

            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            prod_reg <= mul_res;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dt_reg        <= dt_next;
                        e_reg         <= e_next;
                        diff_reg      <= diff_next;
                        bias_reg      <= s_bias_comp;
                        last_time_reg <= s_time_us;
                        last_alt_reg  <= s_measured_alt;
                        state_reg     <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    esum_reg  <= esum_next;
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I: begin
                    p_reg     <= term_next;
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    // The gain-scaled sum always fits 40 bits.
                    a_reg     <= prod_sh[39:0];
                    state_reg <= ST_MUL_AL;
                end
                ST_MUL_AL: begin
                    rdiv_reg  <= prod_reg;
                    state_reg <= ST_MUL_AH;
                end
                ST_MUL_AH: begin
                    acc_reg   <= {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= acc_sum;
                    state_reg <= ST_LD_I;
                end
                ST_LD_I: begin
                    div_quo_reg  <= div_src_abs[MW-1:0];
                    div_rem_reg  <= '0;
                    div_den_reg  <= div_den_next;
                    div_neg_reg  <= div_src[AW-1];
                    div_cnt_reg  <= DCW'(DIV_STEPS - 1);
                    div_rate_reg <= 1'b0;
                    state_reg    <= ST_DIV;
                end
                ST_DIV: begin
                    div_quo_reg <= div_quo_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == '0) begin
                        state_reg <= div_rate_reg ? ST_FIN_R : ST_FIN_I;
                    end
                end
                ST_FIN_I: begin
                    i_reg        <= i_next;
                    div_quo_reg  <= div_src_abs[MW-1:0];
                    div_rem_reg  <= '0;
                    div_den_reg  <= div_den_next;
                    div_neg_reg  <= div_src[AW-1];
                    div_cnt_reg  <= DCW'(DIV_STEPS - 1);
                    div_rate_reg <= 1'b1;
                    state_reg    <= ST_DIV;
                end
                ST_FIN_R: begin
                    rate_reg  <= rate_next;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    state_reg <= ST_TERM_D;
                end
                ST_TERM_D: begin
                    d_reg     <= term_next;
                    lim_reg   <= lim_next;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    comp_reg <= comp_next;
                    if (rate_reg > max_reg) begin
                        max_reg <= rate_reg;
                    end else if (rate_reg < min_reg) begin
                        min_reg <= rate_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // Wait here only while an earlier result beat is still unclaimed.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        out_comp_reg <= comp_reg;
                        out_rate_reg <= rate_reg;
                        out_lim_reg  <= lim_reg;
                        out_max_reg  <= max_reg;
                        out_min_reg  <= min_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `AHP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input taken while busy")
    `AHP_ASSERT_NEXT(a_result_loaded, (state_reg == ST_OUT) && (!m_valid_reg || m_ready), m_valid_reg && s_ready, "result beat not presented")
    `AHP_ASSERT_SAME(a_descent_cap, 1'b1, lim_reg <= DESC_CAP, "descent limiter above its cap")
    `AHP_ASSERT_SAME(a_comp_range, 1'b1, (comp_reg <= COMP_MAX) && (comp_reg >= -COMP_MAX), "throttle compensation out of range")
    `AHP_ASSERT_SAME(a_min_le_max, 1'b1, min_reg <= max_reg, "minimum climb rate above maximum")

endmodule
